[design/nfc_response_frame_parser_core_assert.svh]
// Assertion macros for the response frame parser.
// No dependencies; included by the top level only.
`ifndef NFC_RESPONSE_FRAME_PARSER_CORE_ASSERT_SVH
`define NFC_RESPONSE_FRAME_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define NFCP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nfcp assertion failed");

// Next-cycle implication, disabled during reset.
`define NFCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nfcp assertion failed");

`endif

[design/nfcp_pkg.sv]
// Types and constants shared by the response frame parser.
// No dependencies.
package nfcp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] PreambleByte  = 8'h00;
  localparam logic [ByteW-1:0] StartByte     = 8'hFF;
  localparam logic [ByteW-1:0] PostambleByte = 8'h00;
  localparam logic [ByteW-1:0] LenOverhead   = 8'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgExpCmd  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTfiId   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPayCap  = 2'd2;

  localparam logic [ByteW-1:0] ExpCmdRst = 8'd0;
  localparam logic [ByteW-1:0] TfiIdRst  = 8'd213;
  localparam logic [ByteW-1:0] PayCapRst = 8'd255;

  typedef enum logic [3:0] {
    PhPre0  = 4'd0,
    PhPre1  = 4'd1,
    PhStart = 4'd2,
    PhLen   = 4'd3,
    PhLcs   = 4'd4,
    PhTfi   = 4'd5,
    PhCmd   = 4'd6,
    PhData  = 4'd7,
    PhDcs   = 4'd8,
    PhPost  = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StTimeout = 2'd1,
    StInvalid = 2'd2,
    StNoSpace = 2'd3
  } status_e;

  typedef enum logic {
    KindPayload = 1'b0,
    KindStatus  = 1'b1
  } kind_e;

  typedef enum logic {
    ActByte    = 1'b0,
    ActTimeout = 1'b1
  } action_e;

  typedef struct packed {
    logic [ByteW-1:0] expected_command;
    logic [ByteW-1:0] reader_to_host_id;
    logic [ByteW-1:0] payload_capacity;
  } cfg_t;

  typedef struct packed {
    kind_e            result_kind;
    logic [ByteW-1:0] payload_byte;
    status_e          frame_status;
    logic [ByteW-1:0] payload_count;
    logic             frame_end;
  } res_t;

endpackage

[design/nfcp_if.sv]
// Channel interfaces of the response frame parser: input, result, config.
// Depends on nfcp_pkg.
interface nfcp_in_if import nfcp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, action, rx_byte, input ready);
  modport sink   (input valid, action, rx_byte, output ready);
endinterface

interface nfcp_out_if import nfcp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             result_kind;
  logic [ByteW-1:0] payload_byte;
  logic [1:0]       frame_status;
  logic [ByteW-1:0] payload_count;
  logic             frame_end;

  modport source (output valid, result_kind, payload_byte, frame_status, payload_count,
                  frame_end, input ready);
  modport sink   (input valid, result_kind, payload_byte, frame_status, payload_count,
                  frame_end, output ready);
endinterface

interface nfcp_cfg_if import nfcp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ByteW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/nfcp_cfg.sv]
// Configuration register file of the response frame parser.
// Depends on nfcp_pkg.
module nfcp_cfg import nfcp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_idx_i,
  input  logic [ByteW-1:0]   wr_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_command  <= ExpCmdRst;
      cfg_q.reader_to_host_id <= TfiIdRst;
      cfg_q.payload_capacity  <= PayCapRst;
    end else if (wr_en_i) begin
      case (wr_idx_i)
        CfgExpCmd: cfg_q.expected_command  <= wr_data_i;
        CfgTfiId:  cfg_q.reader_to_host_id <= wr_data_i;
        CfgPayCap: cfg_q.payload_capacity  <= wr_data_i;
        default:   ; // unused index, write dropped
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/nfcp_parser.sv]
// Frame parser state machine: checks one byte or timeout per step.
// Depends on nfcp_pkg.
module nfcp_parser import nfcp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             action_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  cfg_t             cfg_i,
  output logic             res_valid_o,
  output res_t             res_o
);

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] left_q, left_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] total_q, total_d;

  logic [ByteW-1:0] cmd_exp, len_m2, left_m1, sum_add;
  logic             fin;
  status_e          fin_st;

  assign cmd_exp = cfg_i.expected_command + 8'd1;
  assign len_m2  = len_q - LenOverhead;
  assign left_m1 = left_q - 8'd1;
  assign sum_add = sum_q + rx_byte_i;

  // Next state and datapath.
  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    left_d  = left_q;
    sum_d   = sum_q;
    total_d = total_q;
    fin     = 1'b0;
    fin_st  = StOk;
    if (action_i == ActTimeout) begin
      fin    = 1'b1;
      fin_st = StTimeout;
    end else begin
      case (phase_q)
        PhPre0: begin
          if (rx_byte_i != PreambleByte) begin
            fin = 1'b1; fin_st = StInvalid;
          end else phase_d = PhPre1;
        end
        PhPre1: begin
          if (rx_byte_i != PreambleByte) begin
            fin = 1'b1; fin_st = StInvalid;
          end else phase_d = PhStart;
        end
        PhStart: begin
          if (rx_byte_i != StartByte) begin
            fin = 1'b1; fin_st = StInvalid;
          end else phase_d = PhLen;
        end
        PhLen: begin
          len_d   = rx_byte_i;
          phase_d = PhLcs;
        end
        PhLcs: begin
          if (len_q + rx_byte_i != 8'd0) begin
            fin = 1'b1; fin_st = StInvalid;
          end else phase_d = PhTfi;
        end
        PhTfi: begin
          if (rx_byte_i != cfg_i.reader_to_host_id) begin
            fin = 1'b1; fin_st = StInvalid;
          end else begin
            sum_d   = rx_byte_i;
            phase_d = PhCmd;
          end
        end
        PhCmd: begin
          if (rx_byte_i != cmd_exp) begin
            fin = 1'b1; fin_st = StInvalid;
          end else begin
            sum_d   = sum_add;
            total_d = len_m2;
            if (len_m2 > cfg_i.payload_capacity) begin
              fin = 1'b1; fin_st = StNoSpace;
            end else begin
              left_d  = len_m2;
              phase_d = (len_m2 == 8'd0) ? PhDcs : PhData;
            end
          end
        end
        PhData: begin
          sum_d  = sum_add;
          left_d = left_m1;
          if (left_m1 == 8'd0) phase_d = PhDcs;
        end
        PhDcs: begin
          if (sum_add != 8'd0) begin
            fin = 1'b1; fin_st = StInvalid;
          end else phase_d = PhPost;
        end
        PhPost: begin
          fin    = 1'b1;
          fin_st = (rx_byte_i != PostambleByte) ? StInvalid : StOk;
        end
        default: phase_d = PhPre0;
      endcase
    end
    if (fin) phase_d = PhPre0;
  end

  // Result of this step.
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if (fin) begin
      res_valid_o         = 1'b1;
      res_o.result_kind   = KindStatus;
      res_o.frame_status  = fin_st;
      res_o.payload_count = (fin_st == StOk) ? total_d : 8'd0;
      res_o.frame_end     = 1'b1;
    end else if (action_i == ActByte && phase_q == PhData) begin
      res_valid_o        = 1'b1;
      res_o.result_kind  = KindPayload;
      res_o.payload_byte = rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhPre0;
      len_q   <= '0;
      left_q  <= '0;
      sum_q   <= '0;
      total_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      left_q  <= left_d;
      sum_q   <= sum_d;
      total_q <= total_d;
    end
  end

endmodule

[design/nfcp_out_buf.sv]
// Two-entry result buffer between the parser and the result channel.
// Depends on nfcp_pkg.
module nfcp_out_buf import nfcp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic full_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t data_o
);

  res_t       ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign pop     = valid_o && ready_i;
  assign data_o  = ent_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop)      cnt_d = cnt_q + 2'd1;
    else if (!push_i && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_ptr_q] <= push_data_i;
  end

endmodule

[design/nfc_response_frame_parser_core.sv]
// Response frame parser, top level: input register, parser, result buffer.
// An accepted beat's result, if any, goes via the input register and result buffer.
// Throughput: one input beat per cycle, set by the single-step parser logic.
// The input register stalls only when the two-entry result buffer is full.
// Reset (rst_ni, async low): parser waits for the first preamble byte, buffers
// empty, registers at expected_command 0, reader_to_host_id 213, capacity 255.
`include "nfc_response_frame_parser_core_assert.svh"
module nfc_response_frame_parser_core import nfcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  nfcp_in_if.sink     in_i,
  nfcp_out_if.source  out_o,
  nfcp_cfg_if.sink    cfg_i
);

  // Writes always taken; the user, not the block, keeps it idle whenever they come.
  cfg_t cfg;
  assign cfg_i.ready = 1'b1;

  nfcp_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  // Input register: one beat held ahead of the parser.
  logic             s1_valid_q;
  logic             s1_action_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_fire;
  logic             buf_full;
  logic             in_fire;

  // The parser step may go whenever the buffer has room for a result.
  assign s1_fire    = s1_valid_q && !buf_full;
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_action_q <= in_i.action;
      s1_byte_q   <= in_i.rx_byte;
    end
  end

  // Parser: compares and 8-bit sums on the registered beat.
  logic res_valid;
  res_t res;

  nfcp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_fire),
    .action_i    (s1_action_q),
    .rx_byte_i   (s1_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result buffer: parts the parser from a stalled result channel.
  res_t out_data;

  nfcp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_fire && res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .data_o      (out_data)
  );

  assign out_o.result_kind   = out_data.result_kind;
  assign out_o.payload_byte  = out_data.payload_byte;
  assign out_o.frame_status  = out_data.frame_status;
  assign out_o.payload_count = out_data.payload_count;
  assign out_o.frame_end     = out_data.frame_end;

  // An accepted beat always lands in the input register.
  `NFCP_ASSERT_NEXT(a_in_lands, clk_i, rst_ni, in_fire, s1_valid_q)
  // A beat stalled by a full buffer keeps its contents.
  `NFCP_ASSERT_NEXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && buf_full,
                    s1_valid_q && $stable(s1_byte_q) && $stable(s1_action_q))
  // Status results and only they mark the frame end.
  `NFCP_ASSERT_IMPL(a_end_kind, clk_i, rst_ni, out_o.valid,
                    out_o.frame_end == out_o.result_kind)
  // Payload beats carry no status or count.
  `NFCP_ASSERT_IMPL(a_payload_clean, clk_i, rst_ni, out_o.valid && !out_o.result_kind,
                    out_o.frame_status == 2'd0 && out_o.payload_count == 8'd0)

endmodule

[dv/tb_nfc_response_frame_parser_core.sv]
`timescale 1ns / 100ps
// Testbench for nfc_response_frame_parser_core: directed and random response frames
// with a scoreboard that predicts every payload byte and frame status.
// Depends on nfcp_pkg, the nfcp_*_if interfaces and the parser RTL.
module tb_nfc_response_frame_parser_core;
  import nfcp_pkg::*;

  localparam int unsigned NumSettings = 6;      // register settings, reset values first
  localparam int unsigned BeatTarget  = 1850;   // random beats over the whole run
  localparam int unsigned SettingBeats = BeatTarget / NumSettings;
  localparam int unsigned DrainCycles = 4;      // margin for the input register and result buffer to empty
  localparam int unsigned FrameOverhead = 9;    // 00 00 FF LEN LCS TFI CMD DCS 00
  localparam int unsigned MaxPrints = 100;
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;  // unmapped index, write is dropped

  // Predicts the parser beat by beat and checks its result stream in order.
  class frame_scoreboard;
    logic [ByteW-1:0] exp_cmd, tfi_id, pay_cap;
    phase_e           ph;
    logic [ByteW-1:0] len_byte, left, csum, pay_total;
    res_t             expected_q[$];
    int unsigned      errors, n_ok, n_timeout, n_invalid, n_nospace, n_payload;

    function new();
      exp_cmd   = ExpCmdRst;
      tfi_id    = TfiIdRst;
      pay_cap   = PayCapRst;
      ph        = PhPre0;
      len_byte  = '0;
      left      = '0;
      csum      = '0;
      pay_total = '0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
      case (idx)
        CfgExpCmd: exp_cmd = val;
        CfgTfiId:  tfi_id  = val;
        CfgPayCap: pay_cap = val;
        default: ;
      endcase
    endfunction

    function void close_frame(status_e st);
      res_t r;
      r.result_kind   = KindStatus;
      r.payload_byte  = '0;
      r.frame_status  = st;
      r.payload_count = (st == StOk) ? pay_total : '0;
      r.frame_end     = 1'b1;
      expected_q.push_back(r);
      ph = PhPre0;
      case (st)
        StOk:      n_ok++;
        StTimeout: n_timeout++;
        StInvalid: n_invalid++;
        default:   n_nospace++;
      endcase
    endfunction

    // One accepted input beat; queues the result it causes, if any.
    function void note_beat(action_e act, logic [ByteW-1:0] b);
      res_t r;
      if (act == ActTimeout) begin
        close_frame(StTimeout);
        return;
      end
      case (ph)
        PhPre0: if (b != PreambleByte) close_frame(StInvalid); else ph = PhPre1;
        PhPre1: if (b != PreambleByte) close_frame(StInvalid); else ph = PhStart;
        PhStart: if (b != StartByte) close_frame(StInvalid); else ph = PhLen;
        PhLen: begin
          len_byte = b;
          ph = PhLcs;
        end
        PhLcs: begin
          if (ByteW'(len_byte + b) != '0) close_frame(StInvalid);
          else ph = PhTfi;
        end
        PhTfi: begin
          if (b != tfi_id) close_frame(StInvalid);
          else begin
            csum = b;
            ph = PhCmd;
          end
        end
        PhCmd: begin
          if (b != ByteW'(exp_cmd + 8'd1)) close_frame(StInvalid);
          else begin
            csum = csum + b;
            pay_total = len_byte - LenOverhead;   // LEN 0 and 1 wrap to 254 and 255
            if (pay_total > pay_cap) close_frame(StNoSpace);
            else begin
              left = pay_total;
              ph = (left == '0) ? PhDcs : PhData;
            end
          end
        end
        PhData: begin
          csum = csum + b;
          left = left - 8'd1;
          if (left == '0) ph = PhDcs;
          r.result_kind   = KindPayload;
          r.payload_byte  = b;
          r.frame_status  = StOk;
          r.payload_count = '0;
          r.frame_end     = 1'b0;
          expected_q.push_back(r);
          n_payload++;
        end
        PhDcs: if (ByteW'(csum + b) != '0) close_frame(StInvalid); else ph = PhPost;
        PhPost: close_frame((b != PostambleByte) ? StInvalid : StOk);
        default: ph = PhPre0;
      endcase
    endfunction

    task report(string what, logic [ByteW-1:0] got_v, logic [ByteW-1:0] want_v);
      if (errors < MaxPrints)
        $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got_v, want_v);
      errors++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result beat", got.payload_byte, '0);
        return;
      end
      want = expected_q.pop_front();
      if (got.result_kind !== want.result_kind)
        report("result_kind", {7'd0, got.result_kind}, {7'd0, want.result_kind});
      if (got.payload_byte !== want.payload_byte)
        report("payload_byte", got.payload_byte, want.payload_byte);
      if (got.frame_status !== want.frame_status)
        report("frame_status", {6'd0, got.frame_status}, {6'd0, want.frame_status});
      if (got.payload_count !== want.payload_count)
        report("payload_count", got.payload_count, want.payload_count);
      if (got.frame_end !== want.frame_end)
        report("frame_end", {7'd0, got.frame_end}, {7'd0, want.frame_end});
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  nfcp_in_if  in_if ();
  nfcp_out_if out_if ();
  nfcp_cfg_if cfg_if ();

  nfc_response_frame_parser_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  frame_scoreboard sb;
  bit              gaps_on;
  bit              stalls_on;
  int unsigned     beats_sent;
  int unsigned     settings_run;

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly back-to-back, some short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drive one input beat and hold it until the core accepts it. Valid stays
  // high on return so the next beat can follow in the very next cycle.
  task automatic send_beat(input action_e act, input logic [ByteW-1:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid   <= 1'b0;
      in_if.rx_byte <= ByteW'($urandom_range(0, 255));  // junk while idle
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.action  <= act;
    in_if.rx_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_beat(act, b);
    beats_sent++;
  endtask

  // Sender backs off until every predicted result is out and the pipe is empty.
  task automatic stop_and_drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // Build a frame that matches the current registers, optionally flip bits in
  // one byte, send its first cut_len bytes and optionally end with a timeout.
  task automatic send_frame(input int unsigned paylen, input int corrupt_at,
                            input int unsigned cut_len, input bit end_in_timeout);
    logic [ByteW-1:0] fb[$];
    logic [ByteW-1:0] len, cmd, sum, pb;
    len = ByteW'(paylen + 2);
    cmd = sb.exp_cmd + 8'd1;
    sum = sb.tfi_id + cmd;
    fb = {PreambleByte, PreambleByte, StartByte, len, ~len + 8'd1, sb.tfi_id, cmd};
    repeat (paylen) begin
      pb = ByteW'($urandom_range(0, 255));
      sum = sum + pb;
      fb.push_back(pb);
    end
    fb.push_back(~sum + 8'd1);
    fb.push_back(PostambleByte);
    if (corrupt_at >= 0 && corrupt_at < fb.size())
      fb[corrupt_at] = fb[corrupt_at] ^ ByteW'($urandom_range(1, 255));
    for (int i = 0; i < fb.size() && i < cut_len; i++) send_beat(ActByte, fb[i]);
    if (end_in_timeout) send_beat(ActTimeout, ByteW'($urandom_range(0, 255)));
  endtask

  // One random frame attempt. Most are well formed so the payload and checksum
  // phases get real traffic; the rest break the frame somewhere or are noise.
  task automatic random_frame();
    int unsigned pick, paylen, small_max, flen;
    pick      = $urandom_range(0, 99);
    small_max = (sb.pay_cap < 8) ? sb.pay_cap : 8;
    paylen    = $urandom_range(0, small_max);
    flen      = paylen + FrameOverhead;
    if (pick < 55) begin
      send_frame(paylen, -1, flen, 1'b0);
    end else if (pick < 56) begin
      // rare long payload, up to the capacity
      if (sb.pay_cap > 8) paylen = $urandom_range(9, sb.pay_cap);
      send_frame(paylen, -1, paylen + FrameOverhead, 1'b0);
    end else if (pick < 66) begin
      if (sb.pay_cap == 8'hFF) begin
        send_frame(paylen, -1, flen, 1'b0);
      end else begin
        // too long: status comes right after CMD, so stop there
        paylen = $urandom_range(int'(sb.pay_cap) + 1, 255);
        if ($urandom_range(0, 3) == 0 && sb.pay_cap < 8'd254) paylen = $urandom_range(254, 255);
        send_frame(paylen, -1, 7, 1'b0);
      end
    end else if (pick < 81) begin
      send_frame(paylen, $urandom_range(0, flen - 1), flen, 1'b0);
    end else if (pick < 91) begin
      send_frame(paylen, -1, $urandom_range(0, flen - 1), 1'b1);
    end else begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 3) == 0) send_beat(ActTimeout, ByteW'($urandom_range(0, 255)));
        else if ($urandom_range(0, 2) == 0) send_beat(ActByte, PreambleByte);
        else send_beat(ActByte, ByteW'($urandom_range(0, 255)));
      end
    end
  endtask

  // Result side: check at each edge on the values from before it, then pick the
  // next ready level. Stalls are mostly short with a long one now and then.
  initial begin : result_sink
    int unsigned stall_left;
    res_t        got;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got.result_kind   = kind_e'(out_if.result_kind);
        got.payload_byte  = out_if.payload_byte;
        got.frame_status  = status_e'(out_if.frame_status);
        got.payload_count = out_if.payload_count;
        got.frame_end     = out_if.frame_end;
        sb.check_result(got);
      end
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (!stalls_on || $urandom_range(0, 99) < 75) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end
    end
  end

  initial begin : stimulus
    cfg_t             settings [NumSettings];
    int unsigned      setting_end;
    logic [ByteW-1:0] wrap_len;

    sb = new();
    rst_ni         = 1'b0;
    in_if.valid   <= 1'b0;
    in_if.action  <= ActByte;
    in_if.rx_byte <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= CfgExpCmd;
    cfg_if.data   <= '0;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    wrap_len  = 8'd255;

    // First entry is the reset state; the rest cover the register extremes,
    // including a command of FF whose response code wraps to 00 and capacity 0.
    settings[0] = '{ExpCmdRst, TfiIdRst, PayCapRst};
    settings[1] = '{8'hFF, 8'h00, 8'h00};
    settings[2] = '{8'h00, 8'hFF, 8'hFF};
    settings[3] = '{ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)),
                    ByteW'($urandom_range(1, 16))};
    settings[4] = '{ByteW'($urandom_range(0, 255)), TfiIdRst, 8'hFF};
    settings[5] = '{ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)),
                    ByteW'($urandom_range(0, 255))};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: timeout while idle, a one-byte and an empty payload frame, and a
    // length check byte that does not cancel the length.
    send_beat(ActTimeout, 8'hFF);
    send_frame(1, -1, 1 + FrameOverhead, 1'b0);
    send_frame(0, -1, FrameOverhead, 1'b0);
    send_frame(1, 4, 5, 1'b0);

    for (int s = 0; s < NumSettings; s++) begin
      if (s != 0) begin
        // registers only change with the parser quiet
        stop_and_drain();
        write_reg(CfgExpCmd, settings[s].expected_command);
        write_reg(CfgTfiId, settings[s].reader_to_host_id);
        write_reg(CfgPayCap, settings[s].payload_capacity);
        if (s == 2) write_reg(CfgSpare, ByteW'($urandom_range(0, 255)));
        cfg_if.valid <= 1'b0;
      end
      settings_run++;
      // one setting runs with no idling on either side
      gaps_on   = (s != 3);
      stalls_on = (s != 3);
      setting_end = beats_sent + SettingBeats;
      // full capacity: make sure LEN 00 and 01 (payload 254 and 255) are seen
      if (sb.pay_cap == 8'hFF) begin
        send_frame(wrap_len, -1, int'(wrap_len) + FrameOverhead, 1'b0);
        wrap_len = wrap_len ^ 8'd1;
      end
      while (beats_sent < setting_end) begin
        random_frame();
        if ($urandom_range(0, 99) < 3) stop_and_drain();
      end
    end

    stop_and_drain();
    $display("ran %0d input beats under %0d register settings, %0d payload bytes out",
             beats_sent, settings_run, sb.n_payload);
    $display("frame ends: %0d ok, %0d timeout, %0d invalid, %0d no space, %0d mismatches",
             sb.n_ok, sb.n_timeout, sb.n_invalid, sb.n_nospace, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("timed out, %0d results still pending", sb.pending());
    $display("FAIL");
    $finish;
  end

endmodule
